@@ rtl/core/bpenv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpenv_pkg
// Shared types, codes and sizes of the breakpoint envelope generator.
// ----------------------------------------------------------------------------
package bpenv_pkg;

  localparam int unsigned MaxPoints = 16;
  localparam int unsigned IdxW      = $clog2(MaxPoints);
  localparam int unsigned CntW      = $clog2(MaxPoints + 1);

  localparam logic [2:0] ReqInsert   = 3'd0;
  localparam logic [2:0] ReqSetValue = 3'd1;
  localparam logic [2:0] ReqClear    = 3'd2;
  localparam logic [2:0] ReqTick     = 3'd3;
  localparam logic [2:0] ReqSetPos   = 3'd4;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StFull   = 2'd1;
  localparam logic [1:0] StNoMode = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_SCAN,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS_WR,
    S_SEG_RD,
    S_MUL,
    S_DIV,
    S_FIX,
    S_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic             load_req;
    logic             ram_we;
    logic [IdxW-1:0]  ram_addr;
    logic [1:0]       wsel;      // 0 input point, 1 shifted entry, 2 time0/value
    logic             cap_a;     // capture read as lower point
    logic             cap_b;     // capture read as upper point
    logic             mul;
    logic             div_init;
    logic             div_step;
    logic             fix;       // form final sample from quotient
    logic             sel_a;     // sample := lower value
    logic             sel_b;     // sample := upper value
    logic             sel_zero;
    logic             set_cnt;
    logic [CntW-1:0]  cnt_d;
    logic             set_pos;
    logic             inc_pos;
    logic             set_st;
    logic [1:0]       st_d;
    logic             set_valid;
    logic             out_load;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0]      req;
    logic [CntW-1:0] cnt;
    logic            t_gt;     // req time > read time
    logic            t_eq;
    logic            pos_le;   // position <= read time
    logic            pos_lt;   // position < read time
    logic            div_done;
    logic            out_busy;
  } stat_t;

endpackage

@@ rtl/core/bpenv_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpenv_ram
// Generic single port RAM with registered read.
// ----------------------------------------------------------------------------
module bpenv_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;
endmodule

@@ rtl/core/bpenv_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpenv_datapath
// Breakpoint store, position counter, serial divider and output register.
// ----------------------------------------------------------------------------
module bpenv_datapath
  import bpenv_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_t              ctrl_i,
  output stat_t              stat_o,
  input  logic [2:0]         req_type_i,
  input  logic signed [31:0] point_value_i,
  input  logic [31:0]        point_time_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic signed [31:0] sample_value_o,
  output logic               sample_valid_o,
  output logic [1:0]         status_o,
  output logic [4:0]         point_count_o
);
  logic [2:0]      req_q;
  logic [31:0]     val_q, time_q, pos_q;
  logic [CntW-1:0] cnt_q;
  logic [31:0]     rd_t, rd_v, wr_t, wr_v;
  logic [31:0]     ta_q, va_q, tb_q, vb_q;
  logic            neg_q;
  logic [63:0]     prod_q;
  logic [63:0]     rem_q;
  logic [63:0]     quo_q;
  logic [6:0]      dcnt_q;
  logic [31:0]     smp_q;
  logic            ov_q, osv_q;
  logic [31:0]     osmp_q;
  logic [1:0]      ost_q, st_q;
  logic [CntW-1:0] ocnt_q;
  logic            sv_q;

  logic [32:0] diff;
  logic [32:0] mag;
  logic [64:0] rtry;
  logic [63:0] rsh;
  logic [31:0] span;

  always_comb begin
    wr_t = time_q;
    wr_v = val_q;
    case (ctrl_i.wsel)
      2'd1: begin
        wr_t = rd_t;
        wr_v = rd_v;
      end
      2'd2: wr_t = '0;
      default: ;
    endcase
  end

  bpenv_ram #(.Width(32), .Depth(MaxPoints)) u_tram (
    .clk_i, .we_i(ctrl_i.ram_we), .addr_i(ctrl_i.ram_addr), .wdata_i(wr_t), .rdata_o(rd_t)
  );
  bpenv_ram #(.Width(32), .Depth(MaxPoints)) u_vram (
    .clk_i, .we_i(ctrl_i.ram_we), .addr_i(ctrl_i.ram_addr), .wdata_i(wr_v), .rdata_o(rd_v)
  );

  assign diff = {vb_q[31], vb_q} - {va_q[31], va_q};
  assign mag  = diff[32] ? (~diff + 33'd1) : diff;
  assign span = tb_q - ta_q;
  assign rsh  = {rem_q[62:0], quo_q[63]};
  assign rtry = {1'b0, rsh} - {33'd0, span};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_req) begin
      req_q  <= req_type_i;
      val_q  <= point_value_i;
      time_q <= point_time_i;
    end
    if (ctrl_i.cap_a) begin
      ta_q <= rd_t;
      va_q <= rd_v;
    end
    if (ctrl_i.cap_b) begin
      tb_q <= rd_t;
      vb_q <= rd_v;
    end
    if (ctrl_i.mul) begin
      prod_q <= {32'd0, mag[31:0]} * {32'd0, pos_q - ta_q};
      neg_q  <= diff[32];
    end
    if (ctrl_i.div_init) begin
      rem_q  <= '0;
      quo_q  <= mag[32] ? {prod_q[62:0], 1'b0} : prod_q;
      if (mag[32]) begin
        rem_q <= {63'd0, prod_q[63]} ;
      end
    end else if (ctrl_i.div_step) begin
      if (!rtry[64]) begin
        rem_q <= rtry[63:0];
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= rsh;
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
    if (ctrl_i.fix) begin
      smp_q <= neg_q ? va_q - quo_q[31:0] : va_q + quo_q[31:0];
    end else if (ctrl_i.sel_a) begin
      smp_q <= va_q;
    end else if (ctrl_i.sel_b) begin
      smp_q <= vb_q;
    end else if (ctrl_i.sel_zero) begin
      smp_q <= '0;
    end
  end

  // mag stays below 2^32, so the extra product shift for mag[32] at div_init is never taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= CntW'(1);
      pos_q  <= '0;
      dcnt_q <= '0;
      ov_q   <= 1'b0;
      st_q   <= StOk;
      sv_q   <= 1'b0;
    end else begin
      if (ctrl_i.set_cnt) cnt_q <= ctrl_i.cnt_d;
      if (ctrl_i.set_pos) pos_q <= time_q;
      else if (ctrl_i.inc_pos) pos_q <= pos_q + 32'd1;
      if (ctrl_i.div_init) dcnt_q <= 7'd64;
      else if (ctrl_i.div_step) dcnt_q <= dcnt_q - 7'd1;
      if (ctrl_i.load_req) begin
        st_q <= StOk;
        sv_q <= 1'b0;
      end else begin
        if (ctrl_i.set_st) st_q <= ctrl_i.st_d;
        if (ctrl_i.set_valid) sv_q <= 1'b1;
      end
      if (ctrl_i.out_load) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      osmp_q <= sv_q ? smp_q : 32'd0;
      osv_q  <= sv_q;
      ost_q  <= st_q;
      ocnt_q <= cnt_q;
    end
  end

  assign stat_o.req      = req_q;
  assign stat_o.cnt      = cnt_q;
  assign stat_o.t_gt     = time_q > rd_t;
  assign stat_o.t_eq     = time_q == rd_t;
  assign stat_o.pos_le   = pos_q <= rd_t;
  assign stat_o.pos_lt   = pos_q < rd_t;
  assign stat_o.div_done = dcnt_q == 7'd1;
  assign stat_o.out_busy = ov_q && !out_ready_i;

  assign out_valid_o    = ov_q;
  assign sample_value_o = osmp_q;
  assign sample_valid_o = osv_q;
  assign status_o       = ost_q;
  assign point_count_o  = 5'(ocnt_q);
endmodule

@@ rtl/core/bpenv_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpenv_ctrl
// Sequencer for search, shift insert, segment lookup and division.
// ----------------------------------------------------------------------------
module bpenv_ctrl
  import bpenv_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  logic  interp_mode_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);
  state_e          state_q, state_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic            span0_q, span0_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      pos_q   <= '0;
      span0_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pos_q   <= pos_d;
      span0_q <= span0_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    pos_d      = pos_q;
    span0_d    = span0_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    ctrl_o.ram_addr = idx_q[IdxW-1:0];
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        ctrl_o.ram_addr = '0;
        if (in_valid_i) begin
          ctrl_o.load_req = 1'b1;
          idx_d   = '0;
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_OUT;
        case (stat_i.req)
          ReqInsert: begin
            if (stat_i.cnt == '0) begin
              if (stat_i.cnt >= CntW'(MaxPoints)) begin
                ctrl_o.set_st = 1'b1;
                ctrl_o.st_d   = StFull;
              end else begin
                pos_d   = '0;
                state_d = S_INS_WR;
              end
            end else begin
              state_d = S_SCAN;
            end
          end
          ReqSetValue: begin
            ctrl_o.ram_we   = 1'b1;
            ctrl_o.ram_addr = '0;
            ctrl_o.wsel     = 2'd2;
            ctrl_o.set_cnt  = 1'b1;
            ctrl_o.cnt_d    = CntW'(1);
          end
          ReqClear: begin
            ctrl_o.set_cnt = 1'b1;
            ctrl_o.cnt_d   = '0;
          end
          ReqTick: begin
            if (stat_i.cnt == '0) begin
              ctrl_o.sel_zero = 1'b1;
              ctrl_o.set_valid = 1'b1;
              ctrl_o.inc_pos   = 1'b1;
            end else if (stat_i.cnt == CntW'(1) || interp_mode_i) begin
              ctrl_o.ram_addr = '0;
              idx_d   = '0;
              state_d = S_SEG_RD;
            end else begin
              ctrl_o.set_st = 1'b1;
              ctrl_o.st_d   = StNoMode;
            end
          end
          ReqSetPos: ctrl_o.set_pos = 1'b1;
          default: ;
        endcase
      end
      // read data for address idx_q is valid here
      S_SCAN: begin
        if (stat_i.t_gt) begin
          if (idx_q + CntW'(1) >= stat_i.cnt) begin
            if (stat_i.cnt >= CntW'(MaxPoints)) begin
              ctrl_o.set_st = 1'b1;
              ctrl_o.st_d   = StFull;
              state_d = S_OUT;
            end else begin
              pos_d   = IdxW'(idx_q + CntW'(1));
              state_d = S_INS_WR;
            end
          end else begin
            idx_d = idx_q + CntW'(1);
            ctrl_o.ram_addr = IdxW'(idx_q + CntW'(1));
          end
        end else if (stat_i.t_eq) begin
          ctrl_o.ram_we = 1'b1;
          state_d = S_OUT;
        end else if (stat_i.cnt >= CntW'(MaxPoints)) begin
          ctrl_o.set_st = 1'b1;
          ctrl_o.st_d   = StFull;
          state_d = S_OUT;
        end else begin
          pos_d   = idx_q[IdxW-1:0];
          idx_d   = stat_i.cnt;
          ctrl_o.ram_addr = IdxW'(stat_i.cnt - CntW'(1));
          state_d = S_SHIFT_RD;
        end
      end
      // idx_q: destination, data of idx_q-1 arriving
      S_SHIFT_RD: begin
        ctrl_o.ram_addr = IdxW'(idx_q - CntW'(1));
        state_d = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        ctrl_o.ram_we = 1'b1;
        ctrl_o.wsel   = 2'd1;
        if (IdxW'(idx_q - CntW'(1)) == pos_q) begin
          state_d = S_INS_WR;
        end else begin
          idx_d   = idx_q - CntW'(1);
          state_d = S_SHIFT_RD;
        end
      end
      S_INS_WR: begin
        ctrl_o.ram_we   = 1'b1;
        ctrl_o.ram_addr = pos_q;
        ctrl_o.set_cnt  = 1'b1;
        ctrl_o.cnt_d    = stat_i.cnt + CntW'(1);
        state_d = S_OUT;
      end
      // tick: segment search, data of idx_q valid
      S_SEG_RD: begin
        if (idx_q == '0) begin
          ctrl_o.cap_a = 1'b1;
          if (stat_i.pos_le || stat_i.cnt == CntW'(1)) begin
            state_d = S_FIX;
            span0_d = 1'b1;
          end else begin
            idx_d = CntW'(1);
            ctrl_o.ram_addr = IdxW'(1);
          end
        end else if (stat_i.pos_lt) begin
          ctrl_o.cap_b = 1'b1;
          span0_d = 1'b0;
          state_d = S_MUL;
        end else if (idx_q + CntW'(1) >= stat_i.cnt) begin
          ctrl_o.cap_a = 1'b1;
          span0_d = 1'b1;
          state_d = S_FIX;
        end else begin
          ctrl_o.cap_a = 1'b1;
          idx_d = idx_q + CntW'(1);
          ctrl_o.ram_addr = IdxW'(idx_q + CntW'(1));
        end
      end
      S_MUL: begin
        ctrl_o.mul = 1'b1;
        state_d = S_DIV;
        idx_d = '0;
      end
      S_DIV: begin
        if (idx_q == '0) begin
          ctrl_o.div_init = 1'b1;
          idx_d = CntW'(1);
        end else begin
          ctrl_o.div_step = 1'b1;
          if (stat_i.div_done) state_d = S_FIX;
        end
      end
      S_FIX: begin
        if (span0_q) ctrl_o.sel_a = 1'b1;
        else ctrl_o.fix = 1'b1;
        ctrl_o.set_valid = 1'b1;
        ctrl_o.inc_pos   = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!stat_i.out_busy) begin
          ctrl_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

@@ rtl/core/breakpoint_envelope_generator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// breakpoint_envelope_generator_unit
// Time-sorted breakpoint table with a linearly interpolated sample output.
// ----------------------------------------------------------------------------
// One transaction at a time. Set-value, clear, set-position and unknown
// requests go straight from the request read to the result. An insert reads
// one entry a cycle until it finds its slot, then moves each later entry
// with a shift read and a shift write before it writes the new point; to
// append, replace or drop needs no shift. A tick with an empty table or no
// mode goes straight to the result; a held first or last value follows the
// segment scan; an interpolated tick adds a multiply and a 64-step restoring
// divider after the scan. The result register frees the input side once
// loaded; a result left waiting stalls the next transaction just before its
// own result is loaded.
module breakpoint_envelope_generator_unit
  import bpenv_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         req_type_i,
  input  logic signed [31:0] point_value_i,
  input  logic [31:0]        point_time_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] sample_value_o,
  output logic               sample_valid_o,
  output logic [1:0]         status_o,
  output logic [4:0]         point_count_o
);
  logic  mode_q;
  ctrl_t ctrl;
  stat_t stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  bpenv_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .interp_mode_i(mode_q), .stat_i(stat), .ctrl_o(ctrl)
  );

  bpenv_datapath u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .req_type_i, .point_value_i, .point_time_i,
    .out_ready_i, .out_valid_o, .sample_value_o, .sample_valid_o,
    .status_o, .point_count_o
  );
endmodule

@@ tb/sv/bpenv_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpenv_checker
// Watches both channels of the envelope generator, predicts each result from
// its own copy of the breakpoint table, and counts mismatches.
// ----------------------------------------------------------------------------
module bpenv_checker
  import bpenv_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [2:0]         req_type_i,
  input  logic signed [31:0] point_value_i,
  input  logic [31:0]        point_time_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] sample_value_i,
  input  logic               sample_valid_i,
  input  logic [1:0]         status_i,
  input  logic [4:0]         point_count_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic signed [31:0] value;
    logic               valid;
    logic [1:0]         status;
    logic [4:0]         count;
  } env_result_t;

  logic [31:0]        pt_time [MaxPoints];
  logic signed [31:0] pt_val  [MaxPoints];
  int                 pt_count;
  logic [31:0]        position;
  logic               linear_mode;
  env_result_t        expected_q[$];

  assign pending_o = expected_q.size();

  function automatic logic signed [31:0] envelope_at(logic [31:0] t);
    longint v0, v1, diff, mag, dt, span, q;
    if (t <= pt_time[0]) return pt_val[0];
    for (int i = 0; i + 1 < pt_count; i++) begin
      if (t < pt_time[i+1]) begin
        v0 = pt_val[i];
        v1 = pt_val[i+1];
        diff = v1 - v0;
        mag = diff < 0 ? -diff : diff;
        dt = longint'(t) - longint'(pt_time[i]);
        span = longint'(pt_time[i+1]) - longint'(pt_time[i]);
        // mag < 2^32, dt < 2^32: product may exceed 63 bits, use 65-bit math
        q = longint'((65'(mag) * 65'(dt)) / 65'(span));
        return diff < 0 ? 32'(v0 - q) : 32'(v0 + q);
      end
    end
    return pt_val[pt_count-1];
  endfunction

  function automatic env_result_t predict_envelope(logic [2:0] req, logic signed [31:0] v,
                                                   logic [31:0] t);
    env_result_t r;
    int p;
    r = '0;
    r.status = StOk;
    case (req)
      ReqInsert: begin
        p = 0;
        while (p < pt_count && t > pt_time[p]) p++;
        if (p < pt_count && pt_time[p] == t) pt_val[p] = v;
        else if (pt_count >= MaxPoints) r.status = StFull;
        else begin
          for (int k = pt_count; k > p; k--) begin
            pt_time[k] = pt_time[k-1];
            pt_val[k]  = pt_val[k-1];
          end
          pt_time[p] = t;
          pt_val[p]  = v;
          pt_count++;
        end
      end
      ReqSetValue: begin
        pt_count = 1;
        pt_time[0] = '0;
        pt_val[0] = v;
      end
      ReqClear: pt_count = 0;
      ReqTick: begin
        if (pt_count == 0) r.valid = 1'b1;
        else if (pt_count == 1) begin
          r.value = pt_val[0];
          r.valid = 1'b1;
        end else if (linear_mode) begin
          r.value = envelope_at(position);
          r.valid = 1'b1;
        end else r.status = StNoMode;
        if (r.valid) position = position + 32'd1;
      end
      ReqSetPos: position = t;
      default: ;
    endcase
    r.count = 5'(pt_count);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    env_result_t e, a;
    if (!rst_ni) begin
      pt_count = 1;
      position = '0;
      linear_mode = 1'b0;
      fail_count_o = 0;
      expected_q.delete();
      for (int i = 0; i < MaxPoints; i++) begin
        pt_time[i] = '0;
        pt_val[i] = '0;
      end
    end else begin
      if (out_valid_i && out_ready_i) begin
        a = '{sample_value_i, sample_valid_i, status_i, point_count_i};
        if (expected_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected result %h", a);
        end else begin
          e = expected_q.pop_front();
          if (e !== a) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display({"mismatch: exp val %h vld %b st %0d cnt %0d, ",
                        "got val %h vld %b st %0d cnt %0d"},
                       e.value, e.valid, e.status, e.count,
                       a.value, a.valid, a.status, a.count);
          end
        end
      end
      if (in_valid_i && in_ready_i)
        expected_q.insert(expected_q.size(),
                          predict_envelope(req_type_i, point_value_i, point_time_i));
      if (cfg_we_i) linear_mode = cfg_wdata_i;
    end
  end

endmodule

@@ tb/sv/breakpoint_envelope_generator_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// breakpoint_envelope_generator_unit_tb
// Directed and random request streams with random idling on both channels;
// a checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module breakpoint_envelope_generator_unit_tb;
  import bpenv_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_wdata_i = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [2:0]         req_type_i = ReqClear;
  logic signed [31:0] point_value_i = '0;
  logic [31:0]        point_time_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] sample_value_o;
  logic               sample_valid_o;
  logic [1:0]         status_o;
  logic [4:0]         point_count_o;
  int                 fail_count;
  int                 pending;
  int                 cycles = 0;
  bit                 hold_off = 1'b0;

  breakpoint_envelope_generator_unit DUT (.*);

  bpenv_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .req_type_i, .point_value_i, .point_time_i,
    .out_valid_i(out_valid_o), .out_ready_i, .sample_value_i(sample_value_o),
    .sample_valid_i(sample_valid_o), .status_i(status_o), .point_count_i(point_count_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
  endfunction

  // receiver
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) out_ready_i <= 1'b0;
      else if ($urandom_range(0, 3) == 0) begin
        g = gap_len();
        out_ready_i <= 1'b0;
        repeat (g) @(negedge clk_i);
      end else out_ready_i <= 1'b1;
    end
  end

  // valid stays high into the next transaction when there is no gap
  task automatic send_req(logic [2:0] req, logic [31:0] v, logic [31:0] t, bit gaps);
    int g;
    if (gaps && $urandom_range(0, 2) == 0) begin
      g = gap_len();
      if (g > 0) begin
        in_valid_i <= 1'b0;
        repeat (g) @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    point_value_i <= v;
    point_time_i <= t;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain_and_config(logic mode);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (120) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= mode;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_time(int sel);
    case (sel)
      0: return $urandom_range(0, 40);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 40);
      default: return $urandom();
    endcase
  endfunction

  task automatic random_phase(int n, int tsel);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40) send_req(ReqInsert, $urandom(), rand_time(tsel), 1'b1);
      else if (r < 75) send_req(ReqTick, $urandom(), $urandom(), 1'b1);
      else if (r < 83) send_req(ReqSetPos, $urandom(), rand_time(tsel), 1'b1);
      else if (r < 89) send_req(ReqSetValue, $urandom(), $urandom(), 1'b1);
      else if (r < 94) send_req(ReqClear, $urandom(), $urandom(), 1'b1);
      else send_req(3'($urandom_range(5, 7)), $urandom(), $urandom(), 1'b1);
    end
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // directed; reset point is never read before being written
    send_req(ReqSetValue, 32'h8000_0000, 32'h1234, 1'b0);
    send_req(ReqTick, '0, '0, 1'b0);
    send_req(ReqInsert, 32'h7FFF_FFFF, 32'd10, 1'b0);
    send_req(ReqTick, '0, '0, 1'b0);
    send_req(ReqInsert, 32'h0001_0000, 32'd10, 1'b0);
    send_req(ReqSetPos, '0, 32'hFFFF_FFFF, 1'b0);
    send_req(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_req(3'd7, '0, '0, 1'b0);
    drain_and_config(1'b1);
    send_req(ReqTick, '0, '0, 1'b0);
    send_req(ReqTick, '0, '0, 1'b0);
    send_req(ReqTick, '0, '0, 1'b0);
    send_req(ReqInsert, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    send_req(ReqSetPos, '0, 32'h8000_0000, 1'b0);
    send_req(ReqTick, '0, '0, 1'b0);
    for (int i = 0; i < 15; i++) send_req(ReqInsert, $urandom(), 32'd100 + i, 1'b0);
    send_req(ReqInsert, 32'h5555_5555, 32'd100, 1'b0);
    send_req(ReqSetPos, '0, 32'd105, 1'b0);
    send_req(ReqTick, '0, '0, 1'b0);
    send_req(ReqClear, '0, '0, 1'b0);
    send_req(ReqTick, '0, '0, 1'b0);

    // receiver held off while requests keep coming
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_req(ReqInsert, $urandom(), $urandom_range(0, 50), 1'b0);
    join

    random_phase(350, 0);
    drain_and_config(1'b0);
    random_phase(350, 0);
    drain_and_config(1'b1);
    random_phase(350, 2);
    drain_and_config(1'b1);
    random_phase(250, 1);
    drain_and_config(1'b0);
    random_phase(150, 2);
    drain_and_config(1'b1);
    random_phase(150, 0);
    in_valid_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

@@ breakpoint_envelope_generator_unit.f @@
rtl/core/bpenv_pkg.sv
rtl/core/bpenv_ram.sv
rtl/core/bpenv_datapath.sv
rtl/core/bpenv_ctrl.sv
rtl/core/breakpoint_envelope_generator_unit.sv
tb/sv/bpenv_checker.sv
tb/sv/breakpoint_envelope_generator_unit_tb.sv
